[rtl/depth_pixel_plane_inlier_classifier_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the depth pixel plane inlier classifier.
// Each macro samples on the rising clock edge and is off while reset is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_PLANE_INLIER_CLASSIFIER_ASSERT_SVH
`define DEPTH_PIXEL_PLANE_INLIER_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPPIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dppic assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DPPIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dppic assertion failed");

`endif

[rtl/dppic_pkg.sv]
// ----------------------------------------------------------------------------
// dppic_pkg
// Types and constants shared by the depth pixel plane inlier classifier.
// ----------------------------------------------------------------------------
package dppic_pkg;

    localparam int COEF_W       = 48;
    localparam int D_FRAC_BITS  = 24;
    localparam int REG_COUNT    = 8;
    localparam int REG_IDX_W    = 3;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;
    localparam int PLANE_STAGES = 5;
    localparam int PIPE_STAGES  = 6;

    localparam logic [COEF_W-1:0] RIVAL_OFFSET_RESET = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRONT_X_COEF = 3'd0,
        REG_FRONT_Y_COEF = 3'd1,
        REG_FRONT_CONST  = 3'd2,
        REG_FRONT_OFFSET = 3'd3,
        REG_RIVAL_X_COEF = 3'd4,
        REG_RIVAL_Y_COEF = 3'd5,
        REG_RIVAL_CONST  = 3'd6,
        REG_RIVAL_OFFSET = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] x_coef;
        logic signed [COEF_W-1:0] y_coef;
        logic signed [COEF_W-1:0] konst;
        logic signed [COEF_W-1:0] offset;
    } plane_coef_t;

    typedef struct packed {
        logic [PLANE_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

[rtl/dppic_stream_if.sv]
// ----------------------------------------------------------------------------
// dppic_stream_if
// Pixel request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dppic_pixel_if #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_BITS-1:0] pixel_depth;
    logic                  in_mask;
    logic                  depth_ok;

    modport source (
        output valid, pixel_col, pixel_row, pixel_depth, in_mask, depth_ok,
        input  ready
    );
    modport sink (
        input  valid, pixel_col, pixel_row, pixel_depth, in_mask, depth_ok,
        output ready
    );
endinterface

interface dppic_result_if #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  is_inlier;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;
    logic [DEPTH_BITS-1:0] out_depth;

    modport source (
        output valid, is_inlier, out_col, out_row, out_depth,
        input  ready
    );
    modport sink (
        input  valid, is_inlier, out_col, out_row, out_depth,
        output ready
    );
endinterface

[rtl/dppic_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dppic_cfg_regs
// APB register file holding the front and rival plane coefficients.
// ----------------------------------------------------------------------------
module dppic_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dppic_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dppic_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dppic_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output dppic_pkg::plane_coef_t         front,
    output dppic_pkg::plane_coef_t         rival
);
    import dppic_pkg::*;

    logic [COEF_W-1:0] coef_reg  [REG_COUNT];
    logic [COEF_W-1:0] coef_next [REG_COUNT];
    logic              wr_en;
    reg_idx_t          idx;
    logic [COEF_W-1:0] rd_sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            coef_next[i] = coef_reg[i];
        end
        if (wr_en)
        begin
            coef_next[idx] = pwdata[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                coef_reg[i] <= (i == int'(REG_RIVAL_OFFSET)) ? RIVAL_OFFSET_RESET : '0;
            end
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_FRONT_X_COEF: rd_sel = coef_reg[REG_FRONT_X_COEF];
            REG_FRONT_Y_COEF: rd_sel = coef_reg[REG_FRONT_Y_COEF];
            REG_FRONT_CONST:  rd_sel = coef_reg[REG_FRONT_CONST];
            REG_FRONT_OFFSET: rd_sel = coef_reg[REG_FRONT_OFFSET];
            REG_RIVAL_X_COEF: rd_sel = coef_reg[REG_RIVAL_X_COEF];
            REG_RIVAL_Y_COEF: rd_sel = coef_reg[REG_RIVAL_Y_COEF];
            REG_RIVAL_CONST:  rd_sel = coef_reg[REG_RIVAL_CONST];
            REG_RIVAL_OFFSET: rd_sel = coef_reg[REG_RIVAL_OFFSET];
            default:          rd_sel = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_sel);

    assign front.x_coef = coef_reg[REG_FRONT_X_COEF];
    assign front.y_coef = coef_reg[REG_FRONT_Y_COEF];
    assign front.konst  = coef_reg[REG_FRONT_CONST];
    assign front.offset = coef_reg[REG_FRONT_OFFSET];
    assign rival.x_coef = coef_reg[REG_RIVAL_X_COEF];
    assign rival.y_coef = coef_reg[REG_RIVAL_Y_COEF];
    assign rival.konst  = coef_reg[REG_RIVAL_CONST];
    assign rival.offset = coef_reg[REG_RIVAL_OFFSET];

endmodule

[rtl/dppic_plane_dist.sv]
// ----------------------------------------------------------------------------
// dppic_plane_dist
// Five-stage pipeline computing |z*(a*x + b*y + c) + d| for one plane.
// ----------------------------------------------------------------------------
module dppic_plane_dist #(
    parameter int COORD_BITS     = 12,
    parameter int DEPTH_BITS     = 16,
    parameter int COEF_FRAC_BITS = 40,
    parameter int PROD_W         = dppic_pkg::COEF_W + COORD_BITS + 1,
    parameter int SUM_W          = PROD_W + 1,
    parameter int MUL_W          = SUM_W + DEPTH_BITS + 1,
    parameter int DSH_W          = dppic_pkg::COEF_W + COEF_FRAC_BITS
                                   - dppic_pkg::D_FRAC_BITS,
    parameter int T_W            = ((MUL_W > DSH_W) ? MUL_W : DSH_W) + 1
) (
    input  logic                   clk,
    input  dppic_pkg::pipe_ctl_t   ctl,
    input  dppic_pkg::plane_coef_t coef,
    input  logic [COORD_BITS-1:0]  x,
    input  logic [COORD_BITS-1:0]  y,
    input  logic [DEPTH_BITS-1:0]  z,
    output logic [T_W-1:0]         mag
);
    import dppic_pkg::*;

    localparam int D_SHIFT = COEF_FRAC_BITS - D_FRAC_BITS;

    logic signed [PROD_W-1:0] ax_next, by_next, ax_reg, by_reg;
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic signed [MUL_W-1:0]  prod_next, prod_reg;
    logic signed [T_W-1:0]    dist_next, dist_reg;
    logic        [T_W-1:0]    mag_next, mag_reg;

    always_comb
    begin
        ax_next   = PROD_W'(coef.x_coef) * PROD_W'($signed({1'b0, x}));
        by_next   = PROD_W'(coef.y_coef) * PROD_W'($signed({1'b0, y}));
        sum_next  = SUM_W'(ax_reg) + SUM_W'(by_reg) + SUM_W'(coef.konst);
        prod_next = MUL_W'(sum_reg) * MUL_W'($signed({1'b0, z}));
        dist_next = T_W'(prod_reg) + (T_W'(coef.offset) <<< D_SHIFT);
        mag_next  = dist_reg[T_W-1] ? unsigned'(-dist_reg) : unsigned'(dist_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            ax_reg <= ax_next;
            by_reg <= by_next;
        end
        if (ctl.en[1])
        begin
            sum_reg <= sum_next;
        end
        if (ctl.en[2])
        begin
            prod_reg <= prod_next;
        end
        if (ctl.en[3])
        begin
            dist_reg <= dist_next;
        end
        if (ctl.en[4])
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

[rtl/depth_pixel_plane_inlier_classifier.sv]
// ----------------------------------------------------------------------------
// depth_pixel_plane_inlier_classifier
// Classifies depth pixels as front-plane inliers against a rival plane.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Contents
//  pix       in         valid/ready      pixel_col, pixel_row, pixel_depth, in_mask, depth_ok
//  res       out        valid/ready      is_inlier, out_col, out_row, out_depth
//  apb       in         psel/penable     eight plane coefficient registers, 64-bit data
//
//  One pixel is accepted per cycle while the receiver does not stall the pipeline.
//  The six stages are products, coefficient sum, depth multiply, offset add,
//  magnitude, and compare into the output register.
//  A stage holds its data only when it is full and the next stage cannot take it,
//  so bubbles close up under a stall and nothing is lost or repeated.
//  Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module depth_pixel_plane_inlier_classifier #(
    parameter int COORD_BITS     = 12,
    parameter int DEPTH_BITS     = 16,
    parameter int COEF_FRAC_BITS = 40
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dppic_pixel_if.sink                      pix,
    dppic_result_if.source                   res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dppic_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dppic_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dppic_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import dppic_pkg::*;

    localparam int PROD_W = COEF_W + COORD_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MUL_W  = SUM_W + DEPTH_BITS + 1;
    localparam int DSH_W  = COEF_W + COEF_FRAC_BITS - D_FRAC_BITS;
    localparam int T_W    = ((MUL_W > DSH_W) ? MUL_W : DSH_W) + 1;
    localparam logic [T_W-1:0] ONE = T_W'(1) << COEF_FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] depth;
        logic                  active;
    } meta_t;

    plane_coef_t             front, rival;
    pipe_ctl_t               ctl;
    logic [PIPE_STAGES-1:0]  en;
    logic [PIPE_STAGES-1:0]  valid_reg;
    meta_t                   meta_reg [PIPE_STAGES];
    meta_t                   meta_in;
    logic                    inlier_next, inlier_reg;
    logic [T_W-1:0]          mag_front, mag_rival;

    dppic_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .front   (front),
        .rival   (rival)
    );

    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || res.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign ctl.en    = en[PLANE_STAGES-1:0];
    assign pix.ready = en[0];

    assign meta_in.col    = pix.pixel_col;
    assign meta_in.row    = pix.pixel_row;
    assign meta_in.depth  = pix.pixel_depth;
    assign meta_in.active = pix.in_mask && pix.depth_ok;

    dppic_plane_dist #(
        .COORD_BITS     (COORD_BITS),
        .DEPTH_BITS     (DEPTH_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .clk  (clk),
        .ctl  (ctl),
        .coef (front),
        .x    (pix.pixel_col),
        .y    (pix.pixel_row),
        .z    (meta_reg[1].depth),
        .mag  (mag_front)
    );

    dppic_plane_dist #(
        .COORD_BITS     (COORD_BITS),
        .DEPTH_BITS     (DEPTH_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rival (
        .clk  (clk),
        .ctl  (ctl),
        .coef (rival),
        .x    (pix.pixel_col),
        .y    (pix.pixel_row),
        .z    (meta_reg[1].depth),
        .mag  (mag_rival)
    );

    assign inlier_next = meta_reg[PIPE_STAGES-2].active
                         && (mag_front <= ONE) && (mag_front <= mag_rival);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= (k == 0) ? pix.valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            meta_reg[0] <= meta_in;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
        if (en[PIPE_STAGES-1])
        begin
            inlier_reg <= inlier_next;
        end
    end

    assign res.valid     = valid_reg[PIPE_STAGES-1];
    assign res.is_inlier = inlier_reg;
    assign res.out_col   = meta_reg[PIPE_STAGES-1].col;
    assign res.out_row   = meta_reg[PIPE_STAGES-1].row;
    assign res.out_depth = meta_reg[PIPE_STAGES-1].depth;

endmodule

[rtl/dppic_checker.sv]
// ----------------------------------------------------------------------------
// dppic_checker
// Port-level checks on the classifier's occupancy and output handshake.
// ----------------------------------------------------------------------------
`include "depth_pixel_plane_inlier_classifier_assert.svh"

module dppic_checker #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  out_is_inlier,
    input  logic [COORD_BITS-1:0] out_col,
    input  logic [COORD_BITS-1:0] out_row,
    input  logic [DEPTH_BITS-1:0] out_depth
);
    import dppic_pkg::*;

    localparam int CNT_W = $clog2(PIPE_STAGES + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `DPPIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable({out_is_inlier, out_col, out_row, out_depth}))
    `DPPIC_ASSERT_NOW(a_no_phantom, clk, rst_n, cnt_reg == '0, !out_valid)
    `DPPIC_ASSERT_NOW(a_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(PIPE_STAGES))
    `DPPIC_ASSERT_NOW(a_empty_ready, clk, rst_n, cnt_reg == '0, in_ready)
    `DPPIC_ASSERT_NOW(a_full_stall, clk, rst_n,
        (cnt_reg == CNT_W'(PIPE_STAGES)) && !out_ready, !in_ready)

endmodule

bind depth_pixel_plane_inlier_classifier dppic_checker #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
) u_dppic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix.valid),
    .in_ready      (pix.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_is_inlier (res.is_inlier),
    .out_col       (res.out_col),
    .out_row       (res.out_row),
    .out_depth     (res.out_depth)
);

[dv/depth_pixel_plane_inlier_classifier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pixel plane inlier classifier testbench
// Streams depth pixels through the classifier under several front and rival
// plane settings. A local model of the folded plane distances predicts each
// classification, and every result is checked in order against it. Directed
// cases cover the field and coefficient extremes, the unit distance, ties
// with the rival plane and zero depth. They are followed by random planes
// with pixels placed near the front plane, random idle gaps on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module depth_pixel_plane_inlier_classifier_tb;
    import dppic_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int DEPTH_BITS     = 16;
    localparam int COEF_FRAC_BITS = 40;
    localparam int HOLD_CYCLES    = 200;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_PIXELS   = 100;

    localparam logic [127:0] UNIT_DISTANCE = 128'd1 << COEF_FRAC_BITS;
    localparam logic signed [COEF_W-1:0] OFFSET_ONE  = 48'd1 << D_FRAC_BITS;
    localparam logic signed [COEF_W-1:0] OFFSET_HALF = 48'd1 << (D_FRAC_BITS - 1);
    localparam logic signed [COEF_W-1:0] COEF_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN    = 48'h8000_0000_0000;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] depth;
        logic                  in_mask;
        logic                  depth_ok;
    } pixel_t;

    typedef struct packed {
        logic                  is_inlier;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] depth;
    } pixel_class_t;

    localparam plane_coef_t RIVAL_DISABLED = '{x_coef: '0, y_coef: '0, konst: '0,
                                              offset: RIVAL_OFFSET_RESET};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dppic_pixel_if  #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) pix_if ();
    dppic_result_if #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) res_if ();

    depth_pixel_plane_inlier_classifier #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pix(pix_if.sink),
        .res(res_if.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    plane_coef_t  front_model;
    plane_coef_t  rival_plane;
    pixel_class_t pending_classes[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           source_gaps_on = 1'b1;
    bit           sink_stalls_on = 1'b1;
    bit           hold_request = 1'b0;

    always #10 clk = ~clk;

    function automatic logic signed [127:0] plane_slope(input plane_coef_t pl,
                                                       input logic [COORD_BITS-1:0] x,
                                                       input logic [COORD_BITS-1:0] y);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        a = $signed(pl.x_coef);
        b = $signed(pl.y_coef);
        c = $signed(pl.konst);
        return a * $signed(128'(x)) + b * $signed(128'(y)) + c;
    endfunction

    function automatic logic [127:0] plane_distance(input plane_coef_t pl,
                                                   input logic [COORD_BITS-1:0] x,
                                                   input logic [COORD_BITS-1:0] y,
                                                   input logic [DEPTH_BITS-1:0] z);
        logic signed [127:0] d;
        logic signed [127:0] t;
        d = $signed(pl.offset);
        t = plane_slope(pl, x, y) * $signed(128'(z)) + (d <<< (COEF_FRAC_BITS - D_FRAC_BITS));
        return (t < 0) ? -t : t;
    endfunction

    function automatic pixel_class_t classify_pixel(input pixel_t p);
        pixel_class_t r;
        logic [127:0] front_dist;
        logic [127:0] rival_dist;
        front_dist  = plane_distance(front_model, p.col, p.row, p.depth);
        rival_dist  = plane_distance(rival_plane, p.col, p.row, p.depth);
        r.is_inlier = p.in_mask && p.depth_ok && (front_dist <= UNIT_DISTANCE)
                      && (front_dist <= rival_dist);
        r.col       = p.col;
        r.row       = p.row;
        r.depth     = p.depth;
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(input int bits);
        logic signed [63:0] r;
        r = $signed({$urandom, $urandom});
        r = r >>> (63 - bits);
        return r[COEF_W-1:0];
    endfunction

    // Offset is chosen so that the plane crosses a plausible depth at the image center.
    function automatic plane_coef_t random_plane();
        plane_coef_t pl;
        logic signed [127:0] s;
        logic signed [127:0] z_target;
        logic signed [127:0] off;
        pl.x_coef = rand_coef($urandom_range(16, 30));
        pl.y_coef = rand_coef($urandom_range(16, 30));
        pl.konst  = rand_coef($urandom_range(30, 42));
        pl.offset = '0;
        s         = plane_slope(pl, 12'd2048, 12'd2048);
        z_target  = $urandom_range(200, 20000);
        off       = (-(s * z_target)) >>> (COEF_FRAC_BITS - D_FRAC_BITS);
        pl.offset = off[COEF_W-1:0];
        return pl;
    endfunction

    function automatic plane_coef_t full_range_plane();
        plane_coef_t pl;
        pl.x_coef = rand_coef(47);
        pl.y_coef = rand_coef(47);
        pl.konst  = rand_coef(47);
        pl.offset = rand_coef(47);
        return pl;
    endfunction

    function automatic logic [DEPTH_BITS-1:0] aim_depth(input plane_coef_t pl,
                                                       input logic [COORD_BITS-1:0] x,
                                                       input logic [COORD_BITS-1:0] y);
        logic signed [127:0] s;
        logic signed [127:0] d;
        logic signed [127:0] z0;
        s = plane_slope(pl, x, y);
        d = $signed(pl.offset);
        d = d <<< (COEF_FRAC_BITS - D_FRAC_BITS);
        if (s == 0)
            return DEPTH_BITS'($urandom);
        z0 = -d / s + $signed(128'($urandom_range(0, 6))) - 3;
        if (z0 < 0)
            z0 = 0;
        if (z0 > (2 ** DEPTH_BITS) - 1)
            z0 = (2 ** DEPTH_BITS) - 1;
        return z0[DEPTH_BITS-1:0];
    endfunction

    function automatic pixel_t make_pixel(input int col, input int row, input int depth,
                                          input bit in_mask, input bit depth_ok);
        pixel_t p;
        p.col      = COORD_BITS'(col);
        p.row      = COORD_BITS'(row);
        p.depth    = DEPTH_BITS'(depth);
        p.in_mask  = in_mask;
        p.depth_ok = depth_ok;
        return p;
    endfunction

    // Most pixels are active and sit near the front plane; the rest are noise.
    function automatic pixel_t random_pixel(input plane_coef_t pl);
        pixel_t p;
        p.col      = COORD_BITS'($urandom);
        p.row      = COORD_BITS'($urandom);
        p.depth    = DEPTH_BITS'($urandom);
        p.in_mask  = ($urandom_range(0, 99) < 90);
        p.depth_ok = ($urandom_range(0, 99) < 90);
        if ($urandom_range(0, 99) < 80)
            p.depth = aim_depth(pl, p.col, p.row);
        return p;
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!source_gaps_on || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_pixel(input pixel_t p, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            pix_if.valid       <= 1'b0;
            pix_if.pixel_col   <= COORD_BITS'($urandom);
            pix_if.pixel_row   <= COORD_BITS'($urandom);
            pix_if.pixel_depth <= DEPTH_BITS'($urandom);
            pix_if.in_mask     <= 1'($urandom);
            pix_if.depth_ok    <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_if.valid       <= 1'b1;
        pix_if.pixel_col   <= p.col;
        pix_if.pixel_row   <= p.row;
        pix_if.pixel_depth <= p.depth;
        pix_if.in_mask     <= p.in_mask;
        pix_if.depth_ok    <= p.depth_ok;
        do @(posedge clk); while (!pix_if.ready);
        pending_classes.insert(pending_classes.size(), classify_pixel(p));
    endtask

    task automatic drain();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (pending_classes.size() != 0) @(posedge clk);
    endtask

    task automatic write_coef(input reg_idx_t idx, input logic [COEF_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'($urandom);
        paddr   <= APB_ADDR_W'($urandom);
        pwdata  <= {$urandom, $urandom};
    endtask

    task automatic load_planes(input plane_coef_t front, input plane_coef_t rival);
        drain();
        write_coef(REG_FRONT_X_COEF, front.x_coef);
        write_coef(REG_FRONT_Y_COEF, front.y_coef);
        write_coef(REG_FRONT_CONST,  front.konst);
        write_coef(REG_FRONT_OFFSET, front.offset);
        write_coef(REG_RIVAL_X_COEF, rival.x_coef);
        write_coef(REG_RIVAL_Y_COEF, rival.y_coef);
        write_coef(REG_RIVAL_CONST,  rival.konst);
        write_coef(REG_RIVAL_OFFSET, rival.offset);
        front_model = front;
        rival_plane = rival;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_reset_values();
        send_pixel(make_pixel(100, 200, 1500, 1, 1), next_gap());
        send_pixel(make_pixel(100, 200, 1500, 0, 1), next_gap());
        send_pixel(make_pixel(100, 200, 1500, 1, 0), next_gap());
        send_pixel(make_pixel(100, 200, 1500, 0, 0), next_gap());
    endtask

    task automatic test_unit_distance();
        plane_coef_t pl;
        pl = '{x_coef: '0, y_coef: '0, konst: '0, offset: OFFSET_ONE};
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(17, 33, 3000, 1, 1), next_gap());
        pl.offset = -OFFSET_ONE;
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(4000, 9, 250, 1, 1), next_gap());
        pl.offset = OFFSET_ONE + 1;
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(17, 33, 3000, 1, 1), next_gap());
    endtask

    task automatic test_field_extremes();
        plane_coef_t pl;
        pl = '{x_coef: -(48'sd1 <<< 28), y_coef: 48'sd1 <<< 28, konst: '0, offset: '0};
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(4095, 4095, 65535, 1, 1), next_gap());
        send_pixel(make_pixel(0, 4095, 1, 1, 1), next_gap());
        send_pixel(make_pixel(0, 4095, 2, 1, 1), next_gap());
        send_pixel(make_pixel(4095, 0, 0, 1, 1), next_gap());
        send_pixel(make_pixel(0, 0, 65535, 0, 1), next_gap());
    endtask

    task automatic test_rival_tie();
        plane_coef_t pl;
        plane_coef_t rv;
        pl = '{x_coef: '0, y_coef: '0, konst: '0, offset: OFFSET_HALF};
        rv = pl;
        load_planes(pl, rv);
        send_pixel(make_pixel(640, 480, 1200, 1, 1), next_gap());
        rv.offset = OFFSET_HALF - 1;
        load_planes(pl, rv);
        send_pixel(make_pixel(640, 480, 1200, 1, 1), next_gap());
        rv.offset = -OFFSET_HALF;
        load_planes(pl, rv);
        send_pixel(make_pixel(640, 480, 1200, 1, 1), next_gap());
    endtask

    task automatic test_zero_depth();
        plane_coef_t pl;
        pl = random_plane();
        pl.offset = OFFSET_ONE;
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(1234, 2345, 0, 1, 1), next_gap());
        pl.offset = OFFSET_ONE + 1;
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(1234, 2345, 0, 1, 1), next_gap());
    endtask

    task automatic test_register_extremes();
        plane_coef_t pl;
        pl = '{x_coef: COEF_MAX, y_coef: COEF_MAX, konst: COEF_MAX, offset: COEF_MAX};
        load_planes(pl, pl);
        send_pixel(make_pixel(4095, 4095, 65535, 1, 1), next_gap());
        send_pixel(make_pixel(0, 0, 0, 1, 1), next_gap());
        pl = '{x_coef: COEF_MIN, y_coef: COEF_MIN, konst: COEF_MIN, offset: COEF_MIN};
        load_planes(pl, RIVAL_DISABLED);
        send_pixel(make_pixel(4095, 4095, 65535, 1, 1), next_gap());
        send_pixel(make_pixel(0, 0, 0, 1, 1), next_gap());
    endtask

    // The receiver stops for a long stretch while pixels keep coming back to back.
    task automatic test_backpressure();
        plane_coef_t pl;
        plane_coef_t rv;
        pl = random_plane();
        rv = pl;
        rv.offset = pl.offset + rand_coef(D_FRAC_BITS);
        load_planes(pl, rv);
        source_gaps_on = 1'b0;
        hold_request   = 1'b1;
        repeat (40) send_pixel(random_pixel(pl), 0);
        drain();
        source_gaps_on = 1'b1;
    endtask

    task automatic test_random_planes();
        plane_coef_t pl;
        plane_coef_t rv;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            pl = random_plane();
            case (phase % 4)
                0: rv = RIVAL_DISABLED;
                1: rv = pl;
                2:
                begin
                    rv = pl;
                    rv.offset = pl.offset + rand_coef(D_FRAC_BITS);
                end
                default: rv = random_plane();
            endcase
            if (phase == PHASE_COUNT - 2)
            begin
                pl = full_range_plane();
                rv = full_range_plane();
            end
            source_gaps_on = (phase % 5 != 2);
            sink_stalls_on = (phase % 5 != 2);
            load_planes(pl, rv);
            repeat (PHASE_PIXELS) send_pixel(random_pixel(pl), next_gap());
        end
        drain();
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        pixel_class_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_classes.size() == 0)
            begin
                $display("%0t: result with no pending pixel, expected none, actual col %0d row %0d",
                         $time, res_if.out_col, res_if.out_row);
                mismatch_count++;
            end
            else
            begin
                want = pending_classes.pop_front();
                check_field("is_inlier", 32'(want.is_inlier), 32'(res_if.is_inlier));
                check_field("out_col",   32'(want.col),       32'(res_if.out_col));
                check_field("out_row",   32'(want.row),       32'(res_if.out_row));
                check_field("out_depth", 32'(want.depth),     32'(res_if.out_depth));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int roll;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            roll = $urandom_range(0, 99);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls_on && roll < 25)
            begin
                stall_left   = (roll < 22) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_col   = '0;
        pix_if.pixel_row   = '0;
        pix_if.pixel_depth = '0;
        pix_if.in_mask     = 1'b0;
        pix_if.depth_ok    = 1'b0;
        front_model        = '0;
        rival_plane        = RIVAL_DISABLED;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_unit_distance();
        test_field_extremes();
        test_rival_tie();
        test_zero_depth();
        test_register_extremes();
        test_backpressure();
        test_random_planes();

        drain();
        repeat (PIPE_STAGES + 4) @(posedge clk);
        if (mismatch_count == 0 && pending_classes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
